### hdl/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg
// shared constants and register index codes of the pulse waveform generator
// ----------------------------------------------------------------------------
package pwg_pkg;

   localparam int TIME_WIDTH_DEF  = 32;
   localparam int LEVEL_WIDTH_DEF = 16;

   // register index codes of the csr port
   typedef enum logic [2:0] {
      REG_DELAY  = 3'd0,
      REG_RISE   = 3'd1,
      REG_WIDTH  = 3'd2,
      REG_FALL   = 3'd3,
      REG_PERIOD = 3'd4,
      REG_LOW    = 3'd5,
      REG_HIGH   = 3'd6
   } reg_index_type;

endpackage

### hdl/pwg_div.sv
// ----------------------------------------------------------------------------
// pwg_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module pwg_div #(
   parameter int DEN_W  = 32,
   parameter int Q_W    = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  dvd_hi,
   input  logic [Q_W-1:0]    dvd_lo,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side,
   output logic              out_valid,
   output logic [Q_W-1:0]    quot,
   output logic [DEN_W-1:0]  rem,
   output logic [SIDE_W-1:0] side_out
);

   // index 0 is the input, index s is the output of step s
   logic              vld_ff  [Q_W+1];
   logic [DEN_W-1:0]  rem_ff  [Q_W+1];
   logic [Q_W-1:0]    shf_ff  [Q_W+1];
   logic [DEN_W-1:0]  den_ff  [Q_W+1];
   logic [SIDE_W-1:0] side_ff [Q_W+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      rem_ff[0]  = dvd_hi;
      shf_ff[0]  = dvd_lo;
      den_ff[0]  = den;
      side_ff[0] = side;
   end

   for (genvar s = 1; s <= Q_W; s++) begin : g_step
      logic [DEN_W:0]   trial;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   shf_in;

      always_comb begin
         trial  = {rem_ff[s-1], shf_ff[s-1][Q_W-1]} - {1'b0, den_ff[s-1]};
         take   = !trial[DEN_W];
         rem_in = take ? trial[DEN_W-1:0]
                       : {rem_ff[s-1][DEN_W-2:0], shf_ff[s-1][Q_W-1]};
         shf_in = {shf_ff[s-1][Q_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            shf_ff[s]  <= shf_in;
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign quot      = shf_ff[Q_W];
   assign rem       = rem_ff[Q_W];
   assign side_out  = side_ff[Q_W];

endmodule

### hdl/pulse_waveform_generator_unit.sv
// ----------------------------------------------------------------------------
// pulse_waveform_generator_unit
// trapezoidal pulse train level for a sample time given in ticks
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and returns one level per
// request, in order. The phase (time modulo period) comes out of a TIME_WIDTH
// stage divider, one bit per stage, and the ramp value out of a LEVEL_WIDTH + 1
// stage divider after one multiplier stage. The whole pipeline holds while a
// result waits under rsp_stall, so req_stall rises only then. Registers are
// written through the csr port (always ready) and must only change while no
// request is in flight.
module pulse_waveform_generator_unit #(
   parameter int TIME_WIDTH  = pwg_pkg::TIME_WIDTH_DEF,
   parameter int LEVEL_WIDTH = pwg_pkg::LEVEL_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [TIME_WIDTH-1:0]         req_sample_time,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [LEVEL_WIDTH-1:0] rsp_level,
   // register write port
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [(TIME_WIDTH > LEVEL_WIDTH ? TIME_WIDTH : LEVEL_WIDTH)-1:0] csr_data
);
   import pwg_pkg::*;

   localparam int TW = TIME_WIDTH;
   localparam int LW = LEVEL_WIDTH;
   localparam int EW = TW + 2;        // region end sums
   localparam int MW = LW + 1;        // level difference magnitude
   localparam int PW = MW + TW;       // ramp product
   localparam int SW = 2 + LW + MW;   // ramp divider sideband

   // configuration registers
   logic [TW-1:0]        delay_ff, rise_ff, width_ff, fall_ff, period_ff;
   logic signed [LW-1:0] low_ff, high_ff;
   logic [EW-1:0]        e_delay_ff, e_rise_ff, e_high_ff, e_fall_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         rise_ff   <= '0;
         width_ff  <= '0;
         fall_ff   <= '0;
         period_ff <= TW'(1);
         low_ff    <= '0;
         high_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_DELAY:  delay_ff  <= csr_data[TW-1:0];
            REG_RISE:   rise_ff   <= csr_data[TW-1:0];
            REG_WIDTH:  width_ff  <= csr_data[TW-1:0];
            REG_FALL:   fall_ff   <= csr_data[TW-1:0];
            REG_PERIOD: period_ff <= csr_data[TW-1:0];
            REG_LOW:    low_ff    <= csr_data[LW-1:0];
            REG_HIGH:   high_ff   <= csr_data[LW-1:0];
            default:    ;   // unmapped index, write dropped
         endcase
      end
   end

   // region end points, settled long before a request reaches the compare
   always_ff @(posedge clock) begin
      e_delay_ff <= EW'(delay_ff);
      e_rise_ff  <= EW'(delay_ff) + EW'(rise_ff);
      e_high_ff  <= EW'(delay_ff) + EW'(rise_ff) + EW'(width_ff);
      e_fall_ff  <= EW'(delay_ff) + EW'(rise_ff) + EW'(width_ff) + EW'(fall_ff);
   end

   // global advance: the pipe holds only while a finished result is stalled
   logic en;
   logic out_v_ff;
   assign en        = !(out_v_ff && rsp_stall);
   assign req_stall = !en;

   // input stage
   logic          in_v_ff;
   logic [TW-1:0] t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && req_valid) begin
         t_ff <= req_sample_time;
      end
   end

   // phase = time modulo period, a zero period acts as one tick
   logic [TW-1:0] per;
   logic          ph_v;
   logic [TW-1:0] ph;
   logic [TW-1:0] ph_quot;
   logic          ph_side;

   assign per = (period_ff == '0) ? TW'(1) : period_ff;

   pwg_div #(
      .DEN_W  (TW),
      .Q_W    (TW),
      .SIDE_W (1)
   ) u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_v_ff),
      .dvd_hi    ('0),
      .dvd_lo    (t_ff),
      .den       (per),
      .side      (1'b0),
      .out_valid (ph_v),
      .quot      (ph_quot),
      .rem       (ph),
      .side_out  (ph_side)
   );

   // region select; boundary samples belong to the earlier region
   logic                 in_rise, in_high, in_fall;
   logic signed [MW-1:0] diff;
   logic                 ramp_c;
   logic                 neg_c;
   logic signed [LW-1:0] from_c;
   logic [MW-1:0]        mag_c;
   logic [TW-1:0]        num_c, den_c;

   always_comb begin
      in_rise = (EW'(ph) >  e_delay_ff) && (EW'(ph) <= e_rise_ff);
      in_high = (EW'(ph) >  e_rise_ff)  && (EW'(ph) <= e_high_ff);
      in_fall = (EW'(ph) >  e_high_ff)  && (EW'(ph) <= e_fall_ff);
      ramp_c  = in_rise || in_fall;
      from_c  = (in_high || in_fall) ? high_ff : low_ff;
      diff    = in_rise ? (MW'(high_ff) - MW'(low_ff)) : (MW'(low_ff) - MW'(high_ff));
      neg_c   = diff[MW-1];
      mag_c   = neg_c ? MW'(-diff) : MW'(diff);
      num_c   = in_rise ? (ph - e_delay_ff[TW-1:0]) : (ph - e_high_ff[TW-1:0]);
      den_c   = in_rise ? rise_ff : fall_ff;
   end

   logic                 a_v_ff, a_ramp_ff, a_neg_ff;
   logic signed [LW-1:0] a_from_ff;
   logic [MW-1:0]        a_mag_ff;
   logic [TW-1:0]        a_num_ff, a_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= ph_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ramp_ff <= ramp_c;
         a_neg_ff  <= neg_c;
         a_from_ff <= from_c;
         a_mag_ff  <= mag_c;
         a_num_ff  <= num_c;
         a_den_ff  <= den_c;
      end
   end

   // ramp product |high - low| * elapsed
   logic                 b_v_ff, b_ramp_ff, b_neg_ff;
   logic signed [LW-1:0] b_from_ff;
   logic [MW-1:0]        b_mag_ff;
   logic [PW-1:0]        b_prod_ff;
   logic [TW-1:0]        b_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ramp_ff <= a_ramp_ff;
         b_neg_ff  <= a_neg_ff;
         b_from_ff <= a_from_ff;
         b_mag_ff  <= a_mag_ff;
         b_prod_ff <= PW'(a_mag_ff) * PW'(a_num_ff);
         b_den_ff  <= a_den_ff;
      end
   end

   // ramp quotient; elapsed <= duration keeps the upper product below den
   logic          r_v;
   logic [MW-1:0] r_q;
   logic [TW-1:0] r_rem;
   logic [SW-1:0] r_side;

   pwg_div #(
      .DEN_W  (TW),
      .Q_W    (MW),
      .SIDE_W (SW)
   ) u_ramp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_v_ff),
      .dvd_hi    (b_prod_ff[PW-1:MW]),
      .dvd_lo    (b_prod_ff[MW-1:0]),
      .den       (b_den_ff),
      .side      ({b_ramp_ff, b_neg_ff, b_from_ff, b_mag_ff}),
      .out_valid (r_v),
      .quot      (r_q),
      .rem       (r_rem),
      .side_out  (r_side)
   );

   logic                 r_ramp, r_neg;
   logic signed [LW-1:0] r_from;
   logic [MW-1:0]        r_mag;
   logic signed [LW+1:0] lvl_wide;

   always_comb begin
      {r_ramp, r_neg, r_from, r_mag} = r_side;
      if (!r_ramp) begin
         lvl_wide = (LW+2)'(r_from);
      end else if (r_neg) begin
         lvl_wide = (LW+2)'(r_from) - (LW+2)'(r_q);
      end else begin
         lvl_wide = (LW+2)'(r_from) + (LW+2)'(r_q);
      end
   end

   // output register
   logic signed [LW-1:0] out_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= r_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_lvl_ff <= lvl_wide[LW-1:0];
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_level = out_lvl_ff;

   // phase always below the period
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      ph_v |-> (ph < per))
      else $error("phase not below period");

   // a selected ramp has a nonzero duration and elapsed within it
   a_ramp_den: assert property (@(posedge clock) disable iff (reset)
      (a_v_ff && a_ramp_ff) |-> ((a_den_ff != '0) && (a_num_ff <= a_den_ff)))
      else $error("ramp with zero duration or elapsed past end");

   // ramp step never exceeds the level swing
   a_ramp_q: assert property (@(posedge clock) disable iff (reset)
      (r_v && r_ramp) |-> ((r_q <= r_mag) && (r_rem < u_ramp_div.den_ff[MW])))
      else $error("ramp quotient out of range");

   // a stalled pipe keeps its result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_stall) |=> (out_v_ff && $stable(out_lvl_ff)))
      else $error("stalled result lost");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for pulse_waveform_generator_unit: a local level
// predictor fed by accepted requests, in-order result checking, random idling
// ----------------------------------------------------------------------------
class level_scoreboard;
   logic signed [15:0] pending_levels[$];
   int                 errors;
   int                 checked;

   // expected level is computed by the bench and queued per accepted request
   function void note_request(logic signed [15:0] lvl);
      pending_levels.push_back(lvl);
   endfunction

   function void check_level(logic signed [15:0] got);
      logic signed [15:0] exp_lvl;
      if (pending_levels.size() == 0) begin
         $error("level: unexpected result %0d", got);
         errors++;
         return;
      end
      exp_lvl = pending_levels.pop_front();
      checked++;
      if (got !== exp_lvl) begin
         $error("level: expected %0d actual %0d", exp_lvl, got);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pwg_pkg::*;

   localparam int LATENCY = 53;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [31:0]        req_sample_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_level;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   // bench copy of the register file
   logic [31:0]        m_delay, m_rise, m_width, m_fall, m_period;
   logic signed [15:0] m_low, m_high;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_cycles = 0;   // long receiver hold-off, counted down by its own process
   int  sent = 0;
   bit  done = 0;

   level_scoreboard sb;

   pulse_waveform_generator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_time(req_sample_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_level(rsp_level),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ramp value: from + (to - from) * num / den, truncated toward zero
   function automatic logic signed [15:0] ramp_level(logic signed [15:0] from,
         logic signed [15:0] to, logic [63:0] num, logic [63:0] den);
      longint     diff;
      logic [63:0] mag;
      logic [127:0] prod;
      logic [63:0] q;
      diff = longint'(to) - longint'(from);
      mag  = (diff < 0) ? -diff : diff;
      prod = 128'(mag) * 128'(num);
      q    = 64'(prod / 128'(den));
      if (diff < 0) return 16'(longint'(from) - longint'(q));
      return 16'(longint'(from) + longint'(q));
   endfunction

   function automatic logic signed [15:0] pulse_level(logic [31:0] t);
      logic [63:0] per, ph, e_delay, e_rise, e_high, e_fall;
      per     = (m_period == 0) ? 64'd1 : 64'(m_period);
      ph      = 64'(t) % per;
      e_delay = 64'(m_delay);
      e_rise  = e_delay + m_rise;
      e_high  = e_rise + m_width;
      e_fall  = e_high + m_fall;
      if (ph <= e_delay) return m_low;
      if (ph <= e_rise)  return ramp_level(m_low, m_high, ph - e_delay, 64'(m_rise));
      if (ph <= e_high)  return m_high;
      if (ph <= e_fall)  return ramp_level(m_high, m_low, ph - e_high, 64'(m_fall));
      return m_low;
   endfunction

   // register write; out-of-range indexes are ignored by the block
   // csr_valid stays high so writes can follow back to back, csr_release drops it
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_DELAY:  m_delay  = value;
         REG_RISE:   m_rise   = value;
         REG_WIDTH:  m_width  = value;
         REG_FALL:   m_fall   = value;
         REG_PERIOD: m_period = value;
         REG_LOW:    m_low    = value[15:0];
         REG_HIGH:   m_high   = value[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_shape(logic [31:0] d, logic [31:0] r, logic [31:0] w,
         logic [31:0] f, logic [31:0] p, logic [15:0] lo, logic [15:0] hi);
      write_reg(REG_DELAY, d);
      write_reg(REG_RISE, r);
      write_reg(REG_WIDTH, w);
      write_reg(REG_FALL, f);
      write_reg(REG_PERIOD, p);
      write_reg(REG_LOW, {16'h0, lo});
      write_reg(REG_HIGH, {16'h0, hi});
      csr_release();
   endtask

   // wait until every expected level is back, then let the pipe drain
   task automatic drain();
      while (sb.pending_levels.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   // send one request; valid may stay high back to back
   task automatic send_request(logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_time <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(pulse_level(t));
      sent++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   // sample times biased toward the interesting phase regions
   function automatic logic [31:0] pick_time();
      logic [31:0] per, base, ph;
      per = (m_period == 0) ? 32'd1 : m_period;
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         default: begin
            base = per * $urandom_range(50);
            ph   = $urandom_range(3) == 0 ? $urandom() % per :
                   m_delay + $urandom_range(m_rise + m_width + m_fall + 4);
            return base + ph;
         end
      endcase
   endfunction

   task automatic random_shape();
      logic [31:0] d, r, w, f, p;
      d = $urandom_range(40);
      r = $urandom_range(3) == 0 ? 0 : $urandom_range(60);
      w = $urandom_range(50);
      f = $urandom_range(3) == 0 ? 0 : $urandom_range(60);
      p = d + r + w + f + $urandom_range(40) - $urandom_range(20);
      if ($urandom_range(9) == 0) begin
         r = $urandom(); f = $urandom(); p = $urandom();
      end
      load_shape(d, r, w, f, p, $urandom(), $urandom());
   endtask

   // receiver: random stall, plus the long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_level(rsp_level);
   end

   initial begin
      #30ms;
      $display("pulse_waveform_generator_unit verification failed");
      $finish;
   end

   initial begin
      int ph;
      sb = new();
      m_delay = 0; m_rise = 0; m_width = 0; m_fall = 0; m_period = 1;
      m_low = 0; m_high = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: everything low at zero
      send_request(32'h0);
      send_request(32'hFFFF_FFFF);
      end_burst();
      drain();

      // full swing, ramps both ways, boundary samples of each region
      load_shape(10, 8, 5, 7, 40, 16'h8000, 16'h7FFF);
      for (int t = 9; t <= 32; t += 1) if (t <= 12 || t >= 17) send_request(t);
      end_burst();
      drain();
      // zero period, delay equal to period, zero ramps, bad index, huge ramps
      write_reg(REG_PERIOD, 0);
      csr_release();
      send_request($urandom());
      end_burst(); drain();
      load_shape(32'hFFFF_FFFF, 3, 3, 3, 32'hFFFF_FFFF, 16'h1234, 16'h8000);
      send_request(32'hFFFF_FFFE); send_request(32'h5555_AAAA);
      end_burst(); drain();
      load_shape(0, 0, 4, 0, 8, 16'h7FFF, 16'h8000);
      write_reg(3'd7, 32'hFFFF_FFFF);
      csr_release();
      for (int t = 0; t < 8; t++) send_request(t);
      end_burst(); drain();
      load_shape(0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF);
      send_request(32'h8000_0000); send_request(32'hFFFF_FFFE);
      end_burst(); drain();

      // random phases across three idling regimes
      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 76 : 0;
         recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 31 : 0;
         for (int s = 0; s < 6; s++) begin
            random_shape();
            if (ph == 2 && s == 0) hold_cycles = 300;
            for (int n = 0; n < 105; n++) send_request(pick_time());
            end_burst();
            drain();   // sender pauses until all results are back
         end
      end

      done = 1;
      $display("run: %0d requests sent, %0d levels checked over many pulse shapes",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
         $display("pulse_waveform_generator_unit verification clean");
      end else begin
         $display("pulse_waveform_generator_unit verification failed");
      end
      $finish;
   end
endmodule
